### design/ffca_pkg.sv
// shared types and constants for the first-fit coalescing allocator
// no dependencies; imported by the top level, the sequencer, the checker and the testbench
package ffca_pkg;

	// table and address space sizing
	localparam int MAX_EXT   = 64;
	localparam int ADDR_BITS = 32;
	localparam int IDX_W     = $clog2(MAX_EXT);
	localparam int CNT_W     = $clog2(MAX_EXT + 1);
	localparam int LEN_W     = ADDR_BITS + 1;
	// starts can run past the region on overlapping frees, keep headroom
	localparam int START_W   = ADDR_BITS + 2;

	localparam logic [START_W-1:0] SPACE_LIMIT = START_W'(1) << ADDR_BITS;
	localparam logic [CNT_W-1:0]   EXT_FULL    = CNT_W'(MAX_EXT);
	localparam logic [ADDR_BITS-1:0] MIN_RESET = ADDR_BITS'(4096);

	// request modes
	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_FREE    = 2'd1;
	localparam logic [1:0] MODE_RESERVE = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_SPACE = 2'd2,
		ST_ZERO  = 2'd3
	} status_t;

	// one free extent as held in the table memory
	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} ext_t;

	// table memory access from the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		ext_t             wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// finished result of one request
	typedef struct packed {
		status_t            status;
		logic [ADDR_BITS-1:0] offset;
		logic [LEN_W-1:0]   region_bytes;
		logic [LEN_W-1:0]   free_bytes;
		logic [LEN_W-1:0]   largest_free;
		logic [CNT_W-1:0]   extent_count;
	} res_t;

endpackage

### design/first_fit_coalescing_allocator.sv
// Free-extent allocator over a growable byte region. One request is handled at a time; the
// next request is taken as soon as the previous result is in the output register, even
// while that result still waits. A request ends with a statistics walk over the N extents
// in the table; before it come any first-fit or address-order search over the entries,
// any moves of entries when an extent is dropped or inserted, and the doubling steps when
// the region grows. All of it is paced by the single read port of the extent table ram,
// whose data arrives in the cycle after the address.
// top level: output register and instances of ffca_seq and ffca_ram
// depends on ffca_pkg, ffca_ram, ffca_seq
module first_fit_coalescing_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] size_bytes,
	input  logic [31:0] region_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] offset,
	output logic [32:0] region_bytes,
	output logic [32:0] free_bytes,
	output logic [32:0] largest_free,
	output logic [6:0]  extent_count
);
	import ffca_pkg::*;

	mem_req_t mem_req;
	ext_t     rd;
	res_t     res;
	res_t     res_q;
	logic     res_valid;
	logic     res_ready;
	logic     out_valid_q;

	// sequencer
	ffca_seq u_seq (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_wr_data,
		.in_valid,
		.in_ready,
		.mode,
		.size_bytes,
		.region_offset,
		.mem_req,
		.rd,
		.res_valid,
		.res_ready,
		.res
	);

	// extent table
	ffca_ram #(
		.WIDTH($bits(ext_t)),
		.DEPTH(MAX_EXT)
	) u_ram (
		.clk,
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rd)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign offset       = res_q.offset;
	assign region_bytes = res_q.region_bytes;
	assign free_bytes   = res_q.free_bytes;
	assign largest_free = res_q.largest_free;
	assign extent_count = res_q.extent_count;

endmodule

### design/ffca_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/ffca_seq.sv
// request sequencer: first-fit search, growth, carve, merge and table shifts
// depends on ffca_pkg; drives the extent table ram through ffca_pkg::mem_req_t
module ffca_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [31:0]                 cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [31:0]                 size_bytes,
	input  logic [31:0]                 region_offset,
	output ffca_pkg::mem_req_t          mem_req,
	input  ffca_pkg::ext_t              rd,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ffca_pkg::res_t              res
);
	import ffca_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE     = 16'h0001,
		S_FF_RD    = 16'h0002,
		S_FF_CHK   = 16'h0004,
		S_TL_RD    = 16'h0008,
		S_TL_CHK   = 16'h0010,
		S_GROW     = 16'h0020,
		S_DR_RD    = 16'h0040,
		S_DR_WR    = 16'h0080,
		S_FR_RD    = 16'h0100,
		S_FR_CHK   = 16'h0200,
		S_FR_MERGE = 16'h0400,
		S_INS_RD   = 16'h0800,
		S_INS_WR   = 16'h1000,
		S_ST_RD    = 16'h2000,
		S_ST_ACC   = 16'h4000,
		S_DONE     = 16'h8000
	} state_t;

	state_t               state_q;
	logic [1:0]           mode_q;
	logic [ADDR_BITS-1:0] want_q;
	logic [ADDR_BITS-1:0] at_q;
	logic [ADDR_BITS-1:0] min_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     used_q;
	logic [CNT_W-1:0]     right_q;
	logic [LEN_W-1:0]     region_q;
	logic                 grown_q;
	logic                 tail_q;
	logic [START_W-1:0]   tstart_q;
	logic [LEN_W-1:0]     tlen_q;
	logic [LEN_W-1:0]     need_q;
	logic [START_W-1:0]   next_q;
	ext_t                 left_q;
	ext_t                 rgt_q;
	status_t              st_q;
	logic [ADDR_BITS-1:0] where_q;
	logic [LEN_W-1:0]     sum_q;
	logic [LEN_W-1:0]     big_q;

	logic [LEN_W-1:0]   want_x;
	logic [START_W-1:0] region_x;
	logic [START_W:0]   tail_end;
	logic               tail_c;
	logic [LEN_W-1:0]   tlen_c;
	logic [LEN_W-1:0]   need_c;
	logic [START_W-1:0] next0;
	logic [START_W-1:0] added;
	logic               gr_over;
	logic               gr_more;
	logic               gr_same;
	logic               fits;
	logic               has_left;
	logic               has_right;
	logic [START_W-1:0] free_end;
	logic [START_W-1:0] in_end;
	logic [START_W:0]   left_end;
	logic [CNT_W-1:0]   raddr_w;

	assign want_x   = {1'b0, want_q};
	assign region_x = {1'b0, region_q};

	// tail test and growth shortfall
	assign tail_end = {1'b0, rd.start} + {2'b0, rd.len};
	assign tail_c   = (state_q == S_TL_CHK) && (tail_end == {2'b0, region_q});
	assign tlen_c   = tail_c ? rd.len : '0;
	assign need_c   = (want_x > tlen_c) ? (want_x - tlen_c) : '0;
	assign next0    = (region_q == '0) ?
		((min_q == '0) ? START_W'(1) : {2'b0, min_q}) : region_x;

	// doubling loop decisions
	assign added   = next_q - region_x;
	assign gr_over = next_q > SPACE_LIMIT;
	assign gr_more = added < {1'b0, need_q};
	assign gr_same = next_q == region_x;

	// first fit and free neighbor tests
	assign fits      = rd.len >= want_x;
	assign free_end  = {2'b0, at_q} + {2'b0, want_q};
	assign in_end    = {2'b0, region_offset} + {2'b0, size_bytes};
	assign left_end  = {1'b0, left_q.start} + {2'b0, left_q.len};
	assign has_left  = (right_q != '0) && (left_end == {3'b0, at_q});
	assign has_right = (right_q < used_q) && (free_end == rgt_q.start);

	// table read address
	always_comb begin
		unique case (state_q)
			S_TL_RD:  raddr_w = used_q - CNT_W'(1);
			S_DR_RD:  raddr_w = k_q + CNT_W'(1);
			S_INS_RD: raddr_w = k_q - CNT_W'(1);
			default:  raddr_w = k_q;
		endcase
	end

	// table write
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = k_q[IDX_W-1:0];
		mem_req.wdata = rd;
		mem_req.raddr = raddr_w[IDX_W-1:0];
		unique case (state_q)
			S_FF_CHK: begin
				mem_req.we = fits && (rd.len != want_x);
				mem_req.wdata.start = rd.start + {2'b0, want_q};
				mem_req.wdata.len   = rd.len - want_x;
			end
			S_GROW: begin
				if (!gr_over && !gr_more && !gr_same) begin
					if (tail_q) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = IDX_W'(used_q - CNT_W'(1));
						mem_req.wdata.start = tstart_q;
						mem_req.wdata.len   = tlen_q + added[LEN_W-1:0];
					end else if (used_q < EXT_FULL) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = used_q[IDX_W-1:0];
						mem_req.wdata.start = region_x;
						mem_req.wdata.len   = added[LEN_W-1:0];
					end
				end
			end
			S_FR_MERGE: begin
				if (has_left) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = IDX_W'(right_q - CNT_W'(1));
					mem_req.wdata.start = left_q.start;
					mem_req.wdata.len   = has_right ?
						(left_q.len + want_x + rgt_q.len) : (left_q.len + want_x);
				end else if (has_right) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = right_q[IDX_W-1:0];
					mem_req.wdata.start = {2'b0, at_q};
					mem_req.wdata.len   = rgt_q.len + want_x;
				end
			end
			S_INS_RD: begin
				if (k_q == right_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = right_q[IDX_W-1:0];
					mem_req.wdata.start = {2'b0, at_q};
					mem_req.wdata.len   = want_x;
				end
			end
			S_DR_WR, S_INS_WR: begin
				mem_req.we = 1'b1;
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
		end else if (cfg_wr_en) begin
			min_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			region_q <= '0;
			k_q      <= '0;
			grown_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode;
						want_q  <= size_bytes;
						at_q    <= region_offset;
						k_q     <= '0;
						grown_q <= 1'b0;
						st_q    <= ST_OK;
						where_q <= '0;
						sum_q   <= '0;
						big_q   <= '0;
						right_q <= '0;
						if (mode != MODE_NONE && size_bytes == '0) begin
							st_q    <= ST_ZERO;
							state_q <= S_ST_RD;
						end else begin
							unique case (mode)
								MODE_ALLOC:   state_q <= S_FF_RD;
								MODE_RESERVE: state_q <= S_TL_RD;
								MODE_FREE: begin
									if (in_end > {1'b0, region_q}) begin
										st_q    <= ST_SPACE;
										state_q <= S_ST_RD;
									end else begin
										state_q <= S_FR_RD;
									end
								end
								default: state_q <= S_ST_RD;
							endcase
						end
					end
				end
				// first-fit scan
				S_FF_RD: begin
					if (k_q == used_q) begin
						if (grown_q) begin
							st_q    <= ST_SPACE;
							k_q     <= '0;
							state_q <= S_ST_RD;
						end else begin
							state_q <= S_TL_RD;
						end
					end else begin
						state_q <= S_FF_CHK;
					end
				end
				S_FF_CHK: begin
					if (fits) begin
						where_q <= rd.start[ADDR_BITS-1:0];
						if (rd.len == want_x) begin
							state_q <= S_DR_RD;
						end else begin
							k_q     <= '0;
							state_q <= S_ST_RD;
						end
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_FF_RD;
					end
				end
				// growth: tail test then doubling
				S_TL_RD: begin
					if (used_q == '0) begin
						tail_q  <= 1'b0;
						tlen_q  <= '0;
						need_q  <= want_x;
						next_q  <= next0;
						state_q <= S_GROW;
					end else begin
						state_q <= S_TL_CHK;
					end
				end
				S_TL_CHK: begin
					tail_q   <= tail_c;
					tstart_q <= rd.start;
					tlen_q   <= rd.len;
					need_q   <= need_c;
					next_q   <= next0;
					state_q  <= S_GROW;
				end
				S_GROW: begin
					if (gr_over) begin
						st_q    <= ST_SPACE;
						k_q     <= '0;
						state_q <= S_ST_RD;
					end else if (gr_more) begin
						next_q <= next_q << 1;
					end else if (!gr_same && !tail_q && used_q >= EXT_FULL) begin
						st_q    <= ST_FULL;
						k_q     <= '0;
						state_q <= S_ST_RD;
					end else begin
						if (!gr_same) begin
							region_q <= next_q[LEN_W-1:0];
							if (!tail_q) begin
								used_q <= used_q + CNT_W'(1);
							end
						end
						k_q <= '0;
						if (mode_q == MODE_ALLOC) begin
							grown_q <= 1'b1;
							state_q <= S_FF_RD;
						end else begin
							state_q <= S_ST_RD;
						end
					end
				end
				// drop entry k, shift the rest down
				S_DR_RD: begin
					if (k_q + CNT_W'(1) >= used_q) begin
						used_q  <= used_q - CNT_W'(1);
						k_q     <= '0;
						state_q <= S_ST_RD;
					end else begin
						state_q <= S_DR_WR;
					end
				end
				S_DR_WR: begin
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_DR_RD;
				end
				// free: find first extent starting above the freed one
				S_FR_RD: begin
					if (k_q == used_q) begin
						right_q <= k_q;
						state_q <= S_FR_MERGE;
					end else begin
						state_q <= S_FR_CHK;
					end
				end
				S_FR_CHK: begin
					if (rd.start <= {2'b0, at_q}) begin
						left_q  <= rd;
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_FR_RD;
					end else begin
						rgt_q   <= rd;
						right_q <= k_q;
						state_q <= S_FR_MERGE;
					end
				end
				S_FR_MERGE: begin
					if (has_left && has_right) begin
						k_q     <= right_q;
						state_q <= S_DR_RD;
					end else if (has_left || has_right) begin
						k_q     <= '0;
						state_q <= S_ST_RD;
					end else if (used_q >= EXT_FULL) begin
						st_q    <= ST_FULL;
						k_q     <= '0;
						state_q <= S_ST_RD;
					end else begin
						k_q     <= used_q;
						state_q <= S_INS_RD;
					end
				end
				// insert: shift entries up then write the new one
				S_INS_RD: begin
					if (k_q == right_q) begin
						used_q  <= used_q + CNT_W'(1);
						k_q     <= '0;
						state_q <= S_ST_RD;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					k_q     <= k_q - CNT_W'(1);
					state_q <= S_INS_RD;
				end
				// statistics walk over the table
				S_ST_RD: begin
					state_q <= (k_q == used_q) ? S_DONE : S_ST_ACC;
				end
				S_ST_ACC: begin
					sum_q <= sum_q + rd.len;
					if (rd.len > big_q) begin
						big_q <= rd.len;
					end
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_ST_RD;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result
	assign in_ready         = state_q == S_IDLE;
	assign res_valid        = state_q == S_DONE;
	assign res.status       = st_q;
	assign res.offset       = where_q;
	assign res.region_bytes = region_q;
	assign res.free_bytes   = sum_q;
	assign res.largest_free = big_q;
	assign res.extent_count = used_q;

endmodule

### design/ffca_checker.sv
// port-level checks for the allocator, bound to the top level
// depends on ffca_pkg and first_fit_coalescing_allocator
module ffca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] offset,
	input logic [32:0] region_bytes,
	input logic [6:0]  extent_count
);
	import ffca_pkg::*;

	// a result that waits stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// failed requests report no offset
	a_err_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> offset == '0)
		else $error("offset on failed request");

	// region and table stay within bounds
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> region_bytes <= 33'(SPACE_LIMIT) && extent_count <= EXT_FULL)
		else $error("region or table out of range");

endmodule

bind first_fit_coalescing_allocator ffca_checker u_ffca_checker (.*);

### tb/tb_top.sv
// self-checking testbench for the first-fit coalescing allocator
// holds its own allocator model; depends on ffca_pkg and first_fit_coalescing_allocator
`timescale 1ns / 100ps

module tb_top;
	import ffca_pkg::*;

	localparam int          CYCLE_LIMIT = 2000000;
	localparam int          SETTLE      = 450;
	localparam bit [63:0]   LEN_MASK    = (64'd1 << (ADDR_BITS + 1)) - 64'd1;
	localparam bit [63:0]   SPACE_TOP   = 64'd1 << ADDR_BITS;

	typedef struct {
		status_t     status;
		bit [31:0]   offset;
		bit [32:0]   region_bytes;
		bit [32:0]   free_bytes;
		bit [32:0]   largest_free;
		bit [6:0]    extent_count;
	} alloc_result_t;

	typedef struct {
		bit [1:0]      mode;
		bit [31:0]     size;
		bit [31:0]     at;
		bit            typed;
		alloc_result_t res;
	} stim_row_t;

	typedef struct {
		bit [31:0] at;
		bit [31:0] len;
	} live_block_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [31:0] size_bytes = '0;
	logic [31:0] region_offset = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] offset;
	logic [32:0] region_bytes;
	logic [32:0] free_bytes;
	logic [32:0] largest_free;
	logic [6:0]  extent_count;

	// model state
	bit [63:0] ext_start [MAX_EXT];
	bit [63:0] ext_len [MAX_EXT];
	int        ext_used;
	bit [63:0] region_size;
	bit [63:0] min_size;

	alloc_result_t pending_results[$];
	live_block_t   live_blocks[$];
	int            mismatches;
	int            cycles;
	bit            calm;
	bit            hold_req;
	bit            hold_taken;
	int            hold_left;
	alloc_result_t last_pred;

	first_fit_coalescing_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .size_bytes(size_bytes), .region_offset(region_offset),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .offset(offset), .region_bytes(region_bytes),
		.free_bytes(free_bytes), .largest_free(largest_free),
		.extent_count(extent_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// --- allocator model ---
	function automatic void drop_extent(int idx);
		for (int k = idx; k + 1 < ext_used; k++) begin
			ext_start[k] = ext_start[k + 1];
			ext_len[k] = ext_len[k + 1];
		end
		ext_used--;
	endfunction

	function automatic bit tail_free();
		if (ext_used == 0)
			return 1'b0;
		return ext_start[ext_used - 1] + ext_len[ext_used - 1] == region_size;
	endfunction

	function automatic int first_fit(bit [63:0] want);
		for (int k = 0; k < ext_used; k++)
			if (ext_len[k] >= want)
				return k;
		return ext_used;
	endfunction

	function automatic status_t grow_region(bit [63:0] want);
		bit        tail;
		bit [63:0] tail_len, need, grown, added;
		tail = tail_free();
		tail_len = tail ? ext_len[ext_used - 1] : 64'd0;
		need = want > tail_len ? want - tail_len : 64'd0;
		grown = region_size == 0 ? (min_size == 0 ? 64'd1 : min_size) : region_size;
		if (grown > SPACE_TOP)
			return ST_SPACE;
		while (grown - region_size < need) begin
			grown = grown * 2;
			if (grown > SPACE_TOP)
				return ST_SPACE;
		end
		if (grown == region_size)
			return ST_OK;
		added = grown - region_size;
		if (tail) begin
			ext_len[ext_used - 1] = (ext_len[ext_used - 1] + added) & LEN_MASK;
		end else begin
			if (ext_used >= MAX_EXT)
				return ST_FULL;
			ext_start[ext_used] = region_size;
			ext_len[ext_used] = added & LEN_MASK;
			ext_used++;
		end
		region_size = grown;
		return ST_OK;
	endfunction

	function automatic status_t carve(bit [63:0] want, output bit [63:0] where);
		int      idx;
		status_t st;
		where = 0;
		idx = first_fit(want);
		if (idx >= ext_used) begin
			st = grow_region(want);
			if (st != ST_OK)
				return st;
			idx = first_fit(want);
			if (idx >= ext_used)
				return ST_SPACE;
		end
		where = ext_start[idx];
		if (ext_len[idx] == want) begin
			drop_extent(idx);
		end else begin
			ext_start[idx] += want;
			ext_len[idx] -= want;
		end
		return ST_OK;
	endfunction

	function automatic status_t release_extent(bit [63:0] at, bit [63:0] len);
		int right;
		bit has_left, has_right;
		right = 0;
		if (at + len > region_size)
			return ST_SPACE;
		while (right < ext_used && ext_start[right] <= at)
			right++;
		has_left = right > 0 && ext_start[right - 1] + ext_len[right - 1] == at;
		has_right = right < ext_used && at + len == ext_start[right];
		if (has_left && has_right) begin
			ext_len[right - 1] = (ext_len[right - 1] + len + ext_len[right]) & LEN_MASK;
			drop_extent(right);
		end else if (has_left) begin
			ext_len[right - 1] = (ext_len[right - 1] + len) & LEN_MASK;
		end else if (has_right) begin
			ext_start[right] = at;
			ext_len[right] = (ext_len[right] + len) & LEN_MASK;
		end else begin
			if (ext_used >= MAX_EXT)
				return ST_FULL;
			for (int k = ext_used; k > right; k--) begin
				ext_start[k] = ext_start[k - 1];
				ext_len[k] = ext_len[k - 1];
			end
			ext_start[right] = at;
			ext_len[right] = len;
			ext_used++;
		end
		return ST_OK;
	endfunction

	function automatic alloc_result_t predict_request(bit [1:0] m, bit [31:0] sz, bit [31:0] at);
		alloc_result_t r;
		bit [63:0]     where, sum, big;
		status_t       st;
		where = 0;
		sum = 0;
		big = 0;
		st = ST_OK;
		if (m != MODE_NONE && sz == 0) begin
			st = ST_ZERO;
		end else if (m == MODE_ALLOC) begin
			st = carve(64'(sz), where);
			if (st != ST_OK)
				where = 0;
		end else if (m == MODE_FREE) begin
			st = release_extent(64'(at), 64'(sz));
		end else if (m == MODE_RESERVE) begin
			st = grow_region(64'(sz));
		end
		for (int k = 0; k < ext_used; k++) begin
			sum += ext_len[k];
			if (ext_len[k] > big)
				big = ext_len[k];
		end
		r.status = st;
		r.offset = where[31:0];
		r.region_bytes = region_size[32:0];
		r.free_bytes = sum[32:0];
		r.largest_free = big[32:0];
		r.extent_count = 7'(ext_used);
		return r;
	endfunction

	// --- request driver ---
	task automatic send_request(bit [1:0] m, bit [31:0] sz, bit [31:0] at, bit typed,
		alloc_result_t typed_res);
		alloc_result_t r;
		if (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		mode <= m;
		size_bytes <= sz;
		region_offset <= at;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		r = predict_request(m, sz, at);
		last_pred = r;
		pending_results = {pending_results, (typed ? typed_res : r)};
		if (m == MODE_ALLOC && r.status == ST_OK)
			live_blocks = {live_blocks, live_block_t'{r.offset, sz}};
	endtask

	task automatic do_request(bit [1:0] m, bit [31:0] sz, bit [31:0] at);
		alloc_result_t none;
		none = '{ST_OK, 0, 0, 0, 0, 0};
		send_request(m, sz, at, 1'b0, none);
	endtask

	// drain the block, then write the minimum region size
	task automatic set_min_size(bit [31:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		min_size = 64'(value);
	endtask

	function automatic bit [31:0] pick_size();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return $urandom_range(1, 512);
		else if (sel < 92)
			return $urandom_range(1, 65536);
		else
			return $urandom;
	endfunction

	// one random request: mostly allocate and free of live blocks, some noise
	task automatic random_request();
		int          sel, idx;
		live_block_t b;
		sel = $urandom_range(99);
		if (sel < 45) begin
			do_request(MODE_ALLOC, pick_size(), $urandom);
		end else if (sel < 80 && live_blocks.size() != 0) begin
			idx = $urandom_range(live_blocks.size() - 1);
			b = live_blocks[idx];
			live_blocks.delete(idx);
			do_request(MODE_FREE, b.len, b.at);
		end else if (sel < 86) begin
			do_request(MODE_RESERVE, pick_size(), $urandom);
		end else if (sel < 92) begin
			// overlapping, double or out-of-region free
			if (region_size != 0 && $urandom_range(1))
				do_request(MODE_FREE, $urandom_range(1, 256),
					$urandom_range(0, 32'(region_size - 1)));
			else
				do_request(MODE_FREE, $urandom, $urandom);
		end else if (sel < 96) begin
			do_request(2'($urandom_range(0, 2)), 32'd0, $urandom);
		end else begin
			do_request(MODE_NONE, $urandom, $urandom);
		end
	endtask

	// many tiny blocks freed every other one, so the table fills
	task automatic fragment_table();
		live_block_t burst[$];
		for (int k = 0; k < 132; k++) begin
			do_request(MODE_ALLOC, 32'd4, $urandom);
			if (last_pred.status == ST_OK)
				burst = {burst, live_block_t'{last_pred.offset, 32'd4}};
		end
		for (int k = 0; k < burst.size(); k += 2)
			do_request(MODE_FREE, burst[k].len, burst[k].at);
	endtask

	// --- result checker and cycle limit ---
	always @(posedge clk) begin
		alloc_result_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no request pending at cycle %0d", cycles);
			end else begin
				e = pending_results.pop_front();
				if (status != e.status || offset != e.offset
					|| region_bytes != e.region_bytes
					|| free_bytes != e.free_bytes || largest_free != e.largest_free
					|| extent_count != e.extent_count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp st %0d off %h tot %h free %h big %h n %0d",
							e.status, e.offset, e.region_bytes, e.free_bytes,
							e.largest_free, e.extent_count);
						$display("          got st %0d off %h tot %h free %h big %h n %0d",
							status, offset, region_bytes, free_bytes,
							largest_free, extent_count);
					end
				end
			end
		end
	end

	// receiver: random idling and one long hold
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_left = 1500;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 22);
		end
	end

	// --- stimulus ---
	stim_row_t dir_rows [21] = '{
		'{MODE_NONE,    32'd5,          32'd0,          1'b1, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_ALLOC,   32'd0,          32'd0,          1'b1, '{ST_ZERO, 0, 0, 0, 0, 0}},
		'{MODE_FREE,    32'd0,          32'hFFFFFFFF,   1'b1, '{ST_ZERO, 0, 0, 0, 0, 0}},
		'{MODE_RESERVE, 32'd0,          32'd0,          1'b1, '{ST_ZERO, 0, 0, 0, 0, 0}},
		'{MODE_ALLOC,   32'd100,        32'hFFFFFFFF,   1'b1, '{ST_OK, 0, 4096, 3996, 3996, 1}},
		'{MODE_FREE,    32'd200,        32'd4000,       1'b1, '{ST_SPACE, 0, 4096, 3996, 3996, 1}},
		'{MODE_ALLOC,   32'hFFFFFFFF,   32'd0,          1'b1, '{ST_SPACE, 0, 4096, 3996, 3996, 1}},
		'{MODE_ALLOC,   32'd3996,       32'd0,          1'b1, '{ST_OK, 100, 4096, 0, 0, 0}},
		'{MODE_ALLOC,   32'd1,          32'd0,          1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_FREE,    32'd100,        32'd0,          1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_FREE,    32'd3996,       32'd100,        1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_FREE,    32'd1,          32'd4096,       1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_RESERVE, 32'd8192,       32'd0,          1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_RESERVE, 32'd100000,     32'd0,          1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_FREE,    32'd10,         32'd50,         1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_FREE,    32'd10,         32'd50,         1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_ALLOC,   32'h80000000,   32'd0,          1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_RESERVE, 32'hFFFFFFFF,   32'd0,          1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_NONE,    32'd0,          32'hFFFFFFFF,   1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_ALLOC,   32'hFFFFFFFF,   32'hAAAAAAAA,   1'b0, '{ST_OK, 0, 0, 0, 0, 0}},
		'{MODE_FREE,    32'd1,          32'hFFFFFFFF,   1'b0, '{ST_OK, 0, 0, 0, 0, 0}}
	};

	initial begin
		ext_used = 0;
		region_size = 0;
		min_size = 64'(MIN_RESET);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset minimum size
		foreach (dir_rows[i])
			send_request(dir_rows[i].mode, dir_rows[i].size, dir_rows[i].at,
				dir_rows[i].typed, dir_rows[i].res);

		// random phases across minimum sizes, extremes included
		set_min_size(32'd1);
		for (int i = 0; i < 85; i++) begin
			if (i == 40)
				hold_req = 1'b1;
			random_request();
		end
		set_min_size(32'h80000000);
		fragment_table();
		for (int i = 0; i < 85; i++)
			random_request();
		set_min_size(32'd0);
		for (int i = 0; i < 85; i++) begin
			calm = (i >= 20 && i < 75);
			random_request();
		end
		calm = 1'b0;
		set_min_size(32'd4096);
		for (int i = 0; i < 85; i++)
			random_request();

		// wait for the last results
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
